>>> rtl/swh_pkg.sv
package swh_pkg;

    // Configuration port
    localparam int ADDR_W = 3;
    localparam logic REG_SEED  = 1'b0;
    localparam logic REG_GUARD = 1'b1;

    // Multiplier constants
    localparam logic [31:0] K_ABS_W  = 32'h6ff9766f;
    localparam logic [31:0] K_ABS_A  = 32'h525bd4ab;
    localparam logic [31:0] K_STIR_W = 32'h5e6aca55;
    localparam logic [31:0] K_STIR_A = 32'h53987a97;
    localparam logic [31:0] K_STIR_B = 32'he3522d45;
    localparam logic [31:0] K_FIN_A  = 32'heb1bcb4b;
    localparam logic [31:0] K_FIN_B  = 32'h5b15a697;

    // Initial lane values, lane 0 in the low word
    localparam logic [3:0][31:0] LANE_INIT = {
        32'h03707344, 32'h13198a2e, 32'h85a308d3, 32'h243f6a88
    };

    // Operation run by the shared mixing unit
    typedef enum logic [1:0] {
        KIND_ABSORB,
        KIND_STIR,
        KIND_FINISH
    } kind_t;

    typedef logic [2:0] phase_t;

    // Control from the sequencer to the mixing unit
    typedef struct packed {
        kind_t  kind;
        phase_t phase;
    } step_t;

    // Last phase of each operation; the result is ready in that phase
    function automatic phase_t last_phase(kind_t kind);
        phase_t p;
        case (kind)
            KIND_ABSORB: p = 3'd3;
            KIND_STIR:   p = 3'd5;
            KIND_FINISH: p = 3'd6;
            default:     p = 3'd3;
        endcase
        return p;
    endfunction

endpackage

>>> rtl/seeded_word_hash_32.sv
// Channel  Direction  Handshake              Payload
// in       to block   in_valid / in_stall    data_word[31:0], bytes_valid[2:0], last_item
// out      from block out_valid / out_stall  hash_value[31:0]
// cfg      to block   APB psel/penable       paddr[2:0], pwdata[31:0], prdata[31:0]
//
// A full non-last word that is only held leaves in_stall low; one that completes a
// 16-byte block keeps in_stall high through 4 lane absorbs.
// A last item runs the length absorb, the lane combine if a block was seen, a stir
// per held word, a tail absorb if tail bytes and the final scramble, after the
// block absorbs if it completes a block. All steps share one multiply/rotate unit.
// Reset clears lanes to their initial values, counts to zero, seed 0, guard on.
// The result sits in an output register; the next message is taken while it
// waits, and a finished hash waits in its last step while the held result is stalled.
module seeded_word_hash_32 (
    input  logic                        clk,
    input  logic                        rst_n,
    // input items
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [31:0]                 data_word,
    input  logic [2:0]                  bytes_valid,
    input  logic                        last_item,
    // result items
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [31:0]                 hash_value,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [swh_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } state_t;

    typedef enum logic [2:0] {
        J_BLK,
        J_LEN,
        J_L1,
        J_S2,
        J_MIX,
        J_STIR,
        J_TAIL,
        J_FIN
    } job_t;

    state_t         state_reg;
    job_t           job_reg;
    swh_pkg::phase_t phase_reg;
    logic [1:0]     idx_reg;
    logic           last_reg;

    logic [31:0]    lane_reg [4];
    logic [31:0]    held_reg [3];
    logic [1:0]     held_cnt_reg;
    logic [31:0]    byte_total_reg;
    logic           block_seen_reg;
    logic [31:0]    word_reg;
    logic [1:0]     tail_reg;

    logic [31:0]    seed_reg;
    logic           guard_reg;
    logic           out_valid_reg;
    logic [31:0]    hash_reg;

    logic           in_acc;
    logic           full_word;
    logic [1:0]     tail_in;
    logic           cfg_wr;
    logic [31:0]    seed_cfg;
    logic           guard_cfg;
    logic           msg_idle;
    logic [31:0]    guard_add;
    logic [31:0]    seed_add;

    swh_pkg::step_t step;
    logic [31:0]    a_opnd;
    logic [31:0]    a_addend;
    logic [31:0]    w_opnd;
    logic [31:0]    held_rd;
    logic [31:0]    tail_mask;
    logic [31:0]    mix_acc;
    logic [31:0]    mix_prod;
    logic           step_done;
    logic           out_free;

    // Input decode
    assign in_acc    = in_valid && (state_reg == S_IDLE);
    assign full_word = bytes_valid[2];
    assign tail_in   = full_word ? 2'd0 : bytes_valid[1:0];

    // Configuration access
    assign cfg_wr    = psel && penable && pwrite;
    assign seed_cfg  = (cfg_wr && paddr[2] == swh_pkg::REG_SEED) ? pwdata : seed_reg;
    assign guard_cfg = (cfg_wr && paddr[2] == swh_pkg::REG_GUARD) ? pwdata[0] : guard_reg;
    assign msg_idle  = (byte_total_reg == 32'd0) && (held_cnt_reg == 2'd0) && !block_seen_reg;
    assign guard_add = guard_reg ? seed_reg : 32'd0;
    assign seed_add  = guard_reg ? 32'd0 : seed_reg;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == swh_pkg::REG_GUARD) ? {31'd0, guard_reg} : seed_reg;

    // Held word and tail mask selection
    always_comb
    begin
        case (idx_reg)
            2'd0:    held_rd = held_reg[0];
            2'd1:    held_rd = held_reg[1];
            2'd2:    held_rd = held_reg[2];
            default: held_rd = word_reg;
        endcase
        case (tail_reg)
            2'd1:    tail_mask = 32'h000000ff;
            2'd2:    tail_mask = 32'h0000ffff;
            2'd3:    tail_mask = 32'h00ffffff;
            default: tail_mask = 32'h00000000;
        endcase
    end

    // Operands of the current job
    always_comb
    begin
        step.phase = phase_reg;
        step.kind  = swh_pkg::KIND_ABSORB;
        a_opnd     = mix_prod;
        a_addend   = 32'd0;
        w_opnd     = 32'd0;
        case (job_reg)
            J_BLK:
            begin
                a_opnd   = lane_reg[idx_reg];
                a_addend = guard_add;
                w_opnd   = held_rd;
            end
            J_LEN:
            begin
                a_opnd = lane_reg[0];
                w_opnd = byte_total_reg;
            end
            J_L1:
            begin
                w_opnd = lane_reg[1];
            end
            J_S2:
            begin
                a_opnd = lane_reg[2];
                w_opnd = lane_reg[3];
            end
            J_MIX:
            begin
                a_opnd = lane_reg[0];
                w_opnd = mix_prod;
            end
            J_STIR:
            begin
                step.kind = swh_pkg::KIND_STIR;
                a_addend  = guard_add;
                w_opnd    = held_rd;
            end
            J_TAIL:
            begin
                w_opnd = word_reg & tail_mask;
            end
            J_FIN:
            begin
                step.kind = swh_pkg::KIND_FINISH;
            end
            default: ;
        endcase
    end

    assign step_done = (state_reg == S_RUN) && (phase_reg == swh_pkg::last_phase(step.kind));
    assign out_free  = !out_valid_reg || !out_stall;

    swh_mix_unit u_mix (
        .clk      (clk),
        .step     (step),
        .a_opnd   (a_opnd),
        .a_addend (a_addend),
        .w_opnd   (w_opnd),
        .acc      (mix_acc),
        .prod     (mix_prod)
    );

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            word_reg <= data_word;
            tail_reg <= tail_in;
            if (full_word && held_cnt_reg != 2'd3)
            begin
                held_reg[held_cnt_reg] <= data_word;
            end
        end
        if (step_done && job_reg == J_FIN && out_free)
        begin
            hash_reg <= mix_acc;
        end
    end

    // Sequencer and message state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            job_reg        <= J_LEN;
            phase_reg      <= '0;
            idx_reg        <= 2'd0;
            last_reg       <= 1'b0;
            held_cnt_reg   <= 2'd0;
            byte_total_reg <= 32'd0;
            block_seen_reg <= 1'b0;
            seed_reg       <= 32'd0;
            guard_reg      <= 1'b1;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                lane_reg[i] <= swh_pkg::LANE_INIT[i];
            end
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            // register writes; lane 0 restarts from the new values while no byte is counted
            if (cfg_wr)
            begin
                seed_reg  <= seed_cfg;
                guard_reg <= guard_cfg;
                if (msg_idle)
                begin
                    lane_reg[0] <= swh_pkg::LANE_INIT[0] + (guard_cfg ? 32'd0 : seed_cfg);
                end
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        last_reg  <= last_item;
                        phase_reg <= '0;
                        idx_reg   <= 2'd0;
                        if (full_word)
                        begin
                            byte_total_reg <= byte_total_reg + 32'd4;
                            if (held_cnt_reg != 2'd3)
                            begin
                                held_cnt_reg <= held_cnt_reg + 2'd1;
                                if (last_item)
                                begin
                                    state_reg <= S_RUN;
                                    job_reg   <= J_LEN;
                                end
                            end
                            else
                            begin
                                held_cnt_reg   <= 2'd0;
                                block_seen_reg <= 1'b1;
                                state_reg      <= S_RUN;
                                job_reg        <= J_BLK;
                            end
                        end
                        else if (last_item)
                        begin
                            byte_total_reg <= byte_total_reg + {30'd0, tail_in};
                            state_reg      <= S_RUN;
                            job_reg        <= J_LEN;
                        end
                    end
                end
                S_RUN:
                begin
                    if (!step_done)
                    begin
                        phase_reg <= phase_reg + 3'd1;
                    end
                    else
                    begin
                        phase_reg <= '0;
                        case (job_reg)
                            J_BLK:
                            begin
                                lane_reg[idx_reg] <= mix_prod;
                                if (idx_reg == 2'd3)
                                begin
                                    idx_reg <= 2'd0;
                                    job_reg <= J_LEN;
                                    if (!last_reg)
                                    begin
                                        state_reg <= S_IDLE;
                                    end
                                end
                                else
                                begin
                                    idx_reg <= idx_reg + 2'd1;
                                end
                            end
                            J_LEN, J_MIX:
                            begin
                                if (job_reg == J_LEN && block_seen_reg)
                                begin
                                    job_reg <= J_L1;
                                end
                                else if (held_cnt_reg != 2'd0)
                                begin
                                    idx_reg <= 2'd0;
                                    job_reg <= J_STIR;
                                end
                                else if (tail_reg != 2'd0)
                                begin
                                    job_reg <= J_TAIL;
                                end
                                else
                                begin
                                    job_reg <= J_FIN;
                                end
                            end
                            J_L1:
                            begin
                                // park the running lane 0 while lanes 2 and 3 combine
                                lane_reg[0] <= mix_prod;
                                job_reg     <= J_S2;
                            end
                            J_S2:
                            begin
                                job_reg <= J_MIX;
                            end
                            J_STIR:
                            begin
                                if (idx_reg + 2'd1 < held_cnt_reg)
                                begin
                                    idx_reg <= idx_reg + 2'd1;
                                end
                                else if (tail_reg != 2'd0)
                                begin
                                    job_reg <= J_TAIL;
                                end
                                else
                                begin
                                    job_reg <= J_FIN;
                                end
                            end
                            J_TAIL:
                            begin
                                job_reg <= J_FIN;
                            end
                            J_FIN:
                            begin
                                if (out_free)
                                begin
                                    out_valid_reg  <= 1'b1;
                                    state_reg      <= S_IDLE;
                                    job_reg        <= J_LEN;
                                    idx_reg        <= 2'd0;
                                    held_cnt_reg   <= 2'd0;
                                    byte_total_reg <= 32'd0;
                                    block_seen_reg <= 1'b0;
                                    lane_reg[0]    <= swh_pkg::LANE_INIT[0] + seed_add;
                                    lane_reg[1]    <= swh_pkg::LANE_INIT[1];
                                    lane_reg[2]    <= swh_pkg::LANE_INIT[2];
                                    lane_reg[3]    <= swh_pkg::LANE_INIT[3];
                                end
                                else
                                begin
                                    // hold in the last phase until the output register frees
                                    phase_reg <= phase_reg;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign hash_value = hash_reg;

endmodule

>>> rtl/swh_mix_unit.sv
module swh_mix_unit (
    input  logic               clk,
    input  swh_pkg::step_t     step,
    input  logic [31:0]        a_opnd,
    input  logic [31:0]        a_addend,
    input  logic [31:0]        w_opnd,
    output logic [31:0]        acc,
    output logic [31:0]        prod
);

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_SET,
        ACC_ADDROL,
        ACC_ROLP,
        ACC_XSH_ACC,
        ACC_XSH_PROD
    } acc_op_t;

    logic [31:0] acc_reg;
    logic [31:0] prod_reg;
    logic [31:0] acc_next;
    logic [31:0] prod_next;

    acc_op_t     acc_op;
    logic        mul_en;
    logic        mul_from_w;
    logic [31:0] mul_k;
    logic [4:0]  amt;

    logic [31:0] mul_a;
    logic [63:0] mul_full;
    logic [31:0] add_sum;
    logic [31:0] rot_src;
    logic [63:0] rot_dbl;
    logic [31:0] xsh_src;

    // Microcode: which multiply and which add/rotate/xor-shift each phase runs
    always_comb
    begin
        acc_op     = ACC_HOLD;
        mul_en     = 1'b0;
        mul_from_w = 1'b0;
        mul_k      = swh_pkg::K_ABS_W;
        amt        = 5'd0;
        case (step.kind)
            swh_pkg::KIND_ABSORB:
            begin
                case (step.phase)
                    3'd0:
                    begin
                        acc_op     = ACC_SET;
                        mul_en     = 1'b1;
                        mul_from_w = 1'b1;
                        mul_k      = swh_pkg::K_ABS_W;
                    end
                    3'd1:
                    begin
                        acc_op = ACC_ADDROL;
                        amt    = 5'd14;
                    end
                    3'd2:
                    begin
                        mul_en = 1'b1;
                        mul_k  = swh_pkg::K_ABS_A;
                    end
                    default: ;
                endcase
            end
            swh_pkg::KIND_STIR:
            begin
                case (step.phase)
                    3'd0:
                    begin
                        acc_op     = ACC_SET;
                        mul_en     = 1'b1;
                        mul_from_w = 1'b1;
                        mul_k      = swh_pkg::K_STIR_W;
                    end
                    3'd1:
                    begin
                        acc_op = ACC_ADDROL;
                        amt    = 5'd16;
                    end
                    3'd2:
                    begin
                        mul_en = 1'b1;
                        mul_k  = swh_pkg::K_STIR_A;
                    end
                    3'd3:
                    begin
                        acc_op = ACC_ROLP;
                        amt    = 5'd15;
                    end
                    3'd4:
                    begin
                        mul_en = 1'b1;
                        mul_k  = swh_pkg::K_STIR_B;
                    end
                    default: ;
                endcase
            end
            swh_pkg::KIND_FINISH:
            begin
                case (step.phase)
                    3'd0:
                    begin
                        acc_op = ACC_SET;
                    end
                    3'd1:
                    begin
                        acc_op = ACC_XSH_ACC;
                        amt    = 5'd16;
                    end
                    3'd2:
                    begin
                        mul_en = 1'b1;
                        mul_k  = swh_pkg::K_FIN_A;
                    end
                    3'd3:
                    begin
                        acc_op = ACC_XSH_PROD;
                        amt    = 5'd15;
                    end
                    3'd4:
                    begin
                        mul_en = 1'b1;
                        mul_k  = swh_pkg::K_FIN_B;
                    end
                    3'd5:
                    begin
                        acc_op = ACC_XSH_PROD;
                        amt    = 5'd16;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // Shared multiplier, low 32 bits kept
    assign mul_a    = mul_from_w ? w_opnd : acc_reg;
    assign mul_full = mul_a * mul_k;

    // Adder, rotator and xor-shift
    assign add_sum = (acc_op == ACC_SET) ? (a_opnd + a_addend) : (acc_reg + prod_reg);
    assign rot_src = (acc_op == ACC_ROLP) ? prod_reg : add_sum;
    assign rot_dbl = {rot_src, rot_src} << amt;
    assign xsh_src = (acc_op == ACC_XSH_ACC) ? acc_reg : prod_reg;

    always_comb
    begin
        case (acc_op)
            ACC_SET:      acc_next = add_sum;
            ACC_ADDROL:   acc_next = rot_dbl[63:32];
            ACC_ROLP:     acc_next = rot_dbl[63:32];
            ACC_XSH_ACC:  acc_next = xsh_src ^ (xsh_src >> amt);
            ACC_XSH_PROD: acc_next = xsh_src ^ (xsh_src >> amt);
            default:      acc_next = acc_reg;
        endcase
        prod_next = mul_en ? mul_full[31:0] : prod_reg;
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
    end

    assign acc  = acc_reg;
    assign prod = prod_reg;

endmodule

>>> rtl/swh_checker.sv
module swh_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        last_item,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] hash_value
);

    // A waiting result holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hash_value))
        else $error("result changed or dropped while stalled");

    // A non-last item never produces a result
    a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !last_item && !out_valid |=> !out_valid)
        else $error("result after a non-last item");

    // A last item always keeps the block busy in the following cycle
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_item |=> in_stall)
        else $error("block not busy after a last item");

    // A new result appears exactly as the block goes idle
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_stall)
        else $error("result raised while block still busy");

endmodule

bind seeded_word_hash_32 swh_checker u_swh_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .last_item  (last_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hash_value (hash_value)
);
